// ===== rtl/core/ssv_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: shared package
// Operation codes, field widths and default sizes used by the store's modules.
// ----------------------------------------------------------------------------
package ssv_pkg;

   localparam int FUNC_BITS  = 2;
   localparam int INDEX_BITS = 4;
   localparam int DATA_BITS  = 32;

   // The request payload is padded to whole bytes.
   localparam int REQ_TDATA_BITS = ((INDEX_BITS + DATA_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = DATA_BITS;

   localparam int DEFAULT_DEPTH    = 16;
   localparam int DEFAULT_GEN_BITS = 16;

   typedef logic [FUNC_BITS-1:0] func_type;

   localparam func_type FUNC_GET     = 2'd0;
   localparam func_type FUNC_SET     = 2'd1;
   localparam func_type FUNC_SET_ALL = 2'd2;

endpackage

// ===== rtl/core/ssv_entry_mem.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: entry memory
// Single-port-write, single-port-read synchronous memory holding each
// entry's value and generation stamp, with a registered read.
// ----------------------------------------------------------------------------
module ssv_entry_mem
   import ssv_pkg::*;
#(
   parameter int DEPTH    = DEFAULT_DEPTH,
   parameter int WIDTH    = DATA_BITS + DEFAULT_GEN_BITS,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssv_clear_seq.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: clearing sequencer
// Walks every memory address once, one per cycle, after reset and whenever
// a sweep is started.
// ----------------------------------------------------------------------------
module ssv_clear_seq
   import ssv_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic [ADDR_BITS-1:0] addr
);

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   logic                 busy_ff;
   logic                 busy_in;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         if (addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
            addr_in = '0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

// ===== rtl/core/set_all_versioned_store_top.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: top level
// Value store with a constant-time set-all, built around one entry memory.
// ----------------------------------------------------------------------------
// The store takes one transaction per cycle, unless a clearing pass or a
// blocked read stage holds req_tready low. A get passes the registered memory
// read, then the compare against the generation into the output register.
// Set and set-all give no response. While a response waits on rsp_tready, the
// input stops as soon as a further get sits in the read stage. After reset,
// and after a set-all that wraps the generation counter, the block runs a
// clearing pass that writes every entry of the entry memory once, during
// which no transaction is accepted.
module set_all_versioned_store_top
   import ssv_pkg::*;
#(
   parameter int DEPTH    = DEFAULT_DEPTH,
   parameter int GEN_BITS = DEFAULT_GEN_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // index[3:0], data_in[35:4], zero pad
   input  logic [FUNC_BITS-1:0]      req_tuser,  // func[1:0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata   // read_value[31:0]
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MEM_WIDTH = DATA_BITS + GEN_BITS;
   localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

   func_type              req_func;
   logic [INDEX_BITS-1:0] req_index;
   logic [DATA_BITS-1:0]  req_data_in;
   logic [ADDR_BITS-1:0]  req_addr;
   logic                  req_in_range;
   logic                  req_accept;
   logic                  get_accept;
   logic                  set_accept;
   logic                  set_all_accept;
   logic                  gen_wrap;

   logic [GEN_BITS-1:0]   gen_ff;
   logic [GEN_BITS-1:0]   gen_in;
   logic [DATA_BITS-1:0]  shared_ff;
   logic [DATA_BITS-1:0]  shared_in;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s1_in_range_ff;
   logic                  s1_advance;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [DATA_BITS-1:0]  out_data_ff;
   logic [DATA_BITS-1:0]  out_data_in;

   logic                  clr_busy;
   logic [ADDR_BITS-1:0]  clr_addr;

   logic                  mem_wr_en;
   logic [ADDR_BITS-1:0]  mem_wr_addr;
   logic [MEM_WIDTH-1:0]  mem_wr_data;
   logic [MEM_WIDTH-1:0]  mem_rd_data;
   logic [DATA_BITS-1:0]  rd_value;
   logic [GEN_BITS-1:0]   rd_stamp;

   assign req_func     = req_tuser;
   assign req_index    = req_tdata[INDEX_BITS-1:0];
   assign req_data_in  = req_tdata[INDEX_BITS+DATA_BITS-1:INDEX_BITS];
   assign req_addr     = ADDR_BITS'(req_index);
   assign req_in_range = 32'(req_index) < 32'(DEPTH);

   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;

   assign get_accept     = req_accept && (req_func == FUNC_GET);
   assign set_accept     = req_accept && (req_func == FUNC_SET) && req_in_range;
   assign set_all_accept = req_accept && (req_func == FUNC_SET_ALL);
   assign gen_wrap       = set_all_accept && (gen_ff == GEN_MAX);

   always_comb begin
      gen_in    = gen_ff;
      shared_in = shared_ff;
      if (set_all_accept) begin
         shared_in = req_data_in;
         if (gen_wrap) begin
            gen_in = GEN_BITS'(1);
         end else begin
            gen_in = gen_ff + 1'b1;
         end
      end
   end

   assign mem_wr_en   = clr_busy || set_accept;
   assign mem_wr_addr = clr_busy ? clr_addr : req_addr;
   assign mem_wr_data = clr_busy ? '0 : {gen_ff, req_data_in};

   assign rd_value = mem_rd_data[DATA_BITS-1:0];
   assign rd_stamp = mem_rd_data[MEM_WIDTH-1:DATA_BITS];

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_advance) begin
         s1_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         if (!s1_in_range_ff) begin
            out_data_in = '0;
         end else if (gen_ff > rd_stamp) begin
            out_data_in = shared_ff;
         end else begin
            out_data_in = rd_value;
         end
      end
      if (get_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= '0;
         shared_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         shared_ff    <= shared_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (get_accept) begin
         s1_in_range_ff <= req_in_range;
      end
   end

   ssv_entry_mem #(
      .DEPTH (DEPTH),
      .WIDTH (MEM_WIDTH)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (get_accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   ssv_clear_seq #(
      .DEPTH (DEPTH)
   ) u_clear_seq (
      .clock (clock),
      .reset (reset),
      .start (gen_wrap),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // The clearing pass owns the memory write port.
   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) clr_busy |-> !req_tready
   ) else $error("transaction accepted during the clearing pass");

   // A blocked read stage must hold the input side.
   a_stall_holds_input : assert property (
      @(posedge clock) disable iff (reset) (s1_valid_ff && !s1_advance) |-> !req_tready
   ) else $error("input accepted while the read stage is blocked");

   // A generation wrap restarts at one and starts the clearing pass.
   a_wrap_restarts : assert property (
      @(posedge clock) disable iff (reset) gen_wrap |=> (gen_ff == GEN_BITS'(1)) && clr_busy
   ) else $error("generation wrap did not restart the counter and clear");

   // After any set-all the generation is never zero.
   a_gen_nonzero : assert property (
      @(posedge clock) disable iff (reset) set_all_accept |=> (gen_ff != '0)
   ) else $error("generation is zero after a set-all");

   // A get reaches the output register once the read stage moves on.
   a_get_to_output : assert property (
      @(posedge clock) disable iff (reset) (s1_valid_ff && s1_advance) |=> out_valid_ff
   ) else $error("read stage result lost");

endmodule

// ===== tb/ssv_store_checker.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: response checker
// Watches both stream channels of the store, keeps a shadow copy of the entry
// values, stamps, shared value and generation, predicts every get and compares
// the returned read value against the oldest open prediction.
// ----------------------------------------------------------------------------
module ssv_store_checker
   import ssv_pkg::*;
#(
   parameter int DEPTH    = DEFAULT_DEPTH,
   parameter int GEN_BITS = DEFAULT_GEN_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // index[3:0], data_in[35:4], zero pad
   input  logic [FUNC_BITS-1:0]      req_tuser,  // func[1:0]
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // read_value[31:0]
   output int                        fail_count,
   output int                        outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_BITS-1:0] slot_value [DEPTH];
   logic [GEN_BITS-1:0]  slot_stamp [DEPTH];
   logic [DATA_BITS-1:0] common_value;
   logic [GEN_BITS-1:0]  epoch;
   logic [DATA_BITS-1:0] expected_reads [$];
   int                   fails = 0;

   task automatic report_error(input string msg);
      $display("store_checker: at %0t ns: %s", $time, msg);
      fails++;
   endtask

   task automatic clear_store();
      foreach (slot_value[i]) begin
         slot_value[i] = '0;
         slot_stamp[i] = '0;
      end
      common_value = '0;
      epoch        = '0;
      expected_reads.delete();
   endtask

   task automatic apply_request(input func_type f, input logic [INDEX_BITS-1:0] idx,
                                input logic [DATA_BITS-1:0] d);
      logic [DATA_BITS-1:0] value;
      bit                   hit;
      hit = int'(idx) < DEPTH;
      case (f)
         FUNC_GET: begin
            value = '0;
            if (hit) begin
               value = (epoch > slot_stamp[idx]) ? common_value : slot_value[idx];
            end
            expected_reads.push_back(value);
         end
         FUNC_SET: begin
            if (hit) begin
               slot_value[idx] = d;
               slot_stamp[idx] = epoch;
            end
         end
         FUNC_SET_ALL: begin
            common_value = d;
            if (epoch == '1) begin
               foreach (slot_stamp[i]) slot_stamp[i] = '0;
               epoch = GEN_BITS'(1);
            end else begin
               epoch = epoch + 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_read(input logic [DATA_BITS-1:0] got);
      logic [DATA_BITS-1:0] want;
      if (expected_reads.size() == 0) begin
         report_error($sformatf("read value %0d returned with no get pending",
                                $signed(got)));
      end else begin
         want = expected_reads.pop_front();
         if (got !== want) begin
            report_error($sformatf("read_value is %0d (0x%08h), expected %0d (0x%08h)",
                                   $signed(got), got, $signed(want), want));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_store();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_read(rsp_tdata[DATA_BITS-1:0]);
         end
         if (req_tvalid && req_tready) begin
            apply_request(func_type'(req_tuser), req_tdata[INDEX_BITS-1:0],
                          req_tdata[INDEX_BITS +: DATA_BITS]);
         end
      end
      fail_count  <= fails;
      outstanding <= expected_reads.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Set-all versioned store: testbench top
// Drives directed and random get, set and set-all transactions with bursty
// idling and a stalling receiver, and reports the verdict from the checker's
// failure count and its count of unanswered gets.
// ----------------------------------------------------------------------------
module tb_top
   import ssv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH    = DEFAULT_DEPTH;
   localparam int GEN_BITS = DEFAULT_GEN_BITS;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;  // index[3:0], data_in[35:4], zero pad
   logic [FUNC_BITS-1:0]      req_tuser = '0;  // func[1:0]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;      // read_value[31:0]

   int                  fail_count;
   int                  outstanding;
   bit                  idle_on = 1'b1;
   bit                  hold_req = 1'b0;
   int                  burst_left = 0;

   set_all_versioned_store_top #(
      .DEPTH    (DEPTH),
      .GEN_BITS (GEN_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ssv_store_checker #(
      .DEPTH    (DEPTH),
      .GEN_BITS (GEN_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: changing stall patterns, plus a long hold-off on request.
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            mode = (cyc / 97) % 4;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= cyc[3];
            endcase
         end
      end
   end

   function automatic logic [DATA_BITS-1:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input func_type f, input logic [INDEX_BITS-1:0] idx,
                               input logic [DATA_BITS-1:0] d);
      logic [REQ_TDATA_BITS-1:0] word;
      int                        gap;
      gap = 0;
      if (idle_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[INDEX_BITS-1:0] = idx;
      word[INDEX_BITS +: DATA_BITS] = d;
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_reads(input int limit);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin
      int       n;
      int       pick;
      func_type f;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every operation, the unused code.
      send_request(FUNC_GET, 4'd0, 32'h0);
      send_request(FUNC_GET, 4'd15, 32'hFFFF_FFFF);
      send_request(FUNC_SET, 4'd0, 32'h7FFF_FFFF);
      send_request(FUNC_SET, 4'd15, 32'h8000_0000);
      send_request(FUNC_GET, 4'd0, 32'h0);
      send_request(FUNC_GET, 4'd15, 32'h0);
      send_request(FUNC_SET, 4'd5, 32'hFFFF_FFFF);
      send_request(FUNC_GET, 4'd5, 32'h0);
      send_request(FUNC_SET_ALL, 4'd0, 32'h1234_5678);
      send_request(FUNC_GET, 4'd0, 32'h0);
      send_request(FUNC_GET, 4'd15, 32'h0);
      send_request(FUNC_SET, 4'd15, 32'h0);
      send_request(FUNC_GET, 4'd15, 32'h0);
      send_request(FUNC_GET, 4'd7, 32'h0);
      send_request(func_type'(3), 4'd15, 32'hFFFF_FFFF);
      send_request(FUNC_GET, 4'd15, 32'h0);
      send_request(FUNC_SET_ALL, 4'd15, 32'h0);
      send_request(FUNC_SET, 4'd10, 32'hA5A5_A5A5);
      send_request(FUNC_GET, 4'd10, 32'h0);
      send_request(FUNC_GET, 4'd9, 32'h0);
      send_request(FUNC_SET_ALL, 4'd3, 32'h8000_0000);
      send_request(FUNC_GET, 4'd10, 32'h0);
      send_request(FUNC_GET, 4'd9, 32'h5A5A_5A5A);

      // Random traffic, with a long receiver hold-off and a full drain inside.
      n = 0;
      while (n < 1300) begin
         if (n == 500) begin
            idle_on = 1'b0;
            hold_req = 1'b1;
            repeat (40) send_request(FUNC_GET, 4'($urandom_range(0, 15)), $urandom);
            idle_on = 1'b1;
         end
         if (n == 1000) begin
            drain_reads(5000);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) f = FUNC_GET;
         else if (pick < 82) f = FUNC_SET;
         else if (pick < 97) f = FUNC_SET_ALL;
         else f = func_type'(3);
         send_request(f, 4'($urandom_range(0, 15)), pick_data());
         if (f != func_type'(3)) n++;
      end

      send_request(FUNC_SET, 4'd3, 32'h0BAD_CAFE);
      send_request(FUNC_SET_ALL, 4'd0, 32'h1111_1111);
      send_request(FUNC_SET, 4'd5, 32'h2222_2222);
      send_request(FUNC_GET, 4'd3, 32'h0);
      send_request(FUNC_GET, 4'd5, 32'h0);
      send_request(FUNC_SET_ALL, 4'd0, 32'h3333_3333);
      send_request(FUNC_GET, 4'd5, 32'h0);
      send_request(FUNC_GET, 4'd3, 32'h0);
      send_request(FUNC_SET, 4'd7, 32'h4444_4444);
      send_request(FUNC_GET, 4'd7, 32'h0);
      send_request(FUNC_GET, 4'd0, 32'h0);
      send_request(FUNC_SET_ALL, 4'd0, 32'h5555_5555);
      send_request(FUNC_GET, 4'd7, 32'h0);
      repeat (30) begin
         pick = $urandom_range(0, 2);
         send_request(func_type'(pick), 4'($urandom_range(0, 15)), pick_data());
      end

      drain_reads(20000);
      repeat (10) @(posedge clock);
      if (outstanding != 0) begin
         $display("tb_top: %0d get transactions never answered", outstanding);
      end
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
